// ===== hw/rtl/qts_pkg.sv =====
// shared types, constants and helpers of the quintic trajectory sampler
// no dependencies; imported by qts_ctrl, qts_dp and the top level
`default_nettype none

package qts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int STEP_W_T      = 31;
    localparam int COUNT_W       = 16;
    localparam int LEFT_W        = 17;
    localparam int CFG_IDX_W     = 3;

    // horner steps: position 0..4, velocity 5..8, acceleration 9..11
    localparam int NUM_STEPS     = 12;
    localparam int STEP_W        = 4;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_POS_LAST = step_t'(4);
    localparam step_t STEP_VEL_LAST = step_t'(8);
    localparam step_t STEP_ACC_LAST = step_t'(NUM_STEPS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_0     = 3'd0,
        CFG_COEF_1     = 3'd1,
        CFG_COEF_2     = 3'd2,
        CFG_COEF_3     = 3'd3,
        CFG_COEF_4     = 3'd4,
        CFG_COEF_5     = 3'd5,
        CFG_START_TIME = 3'd6,
        CFG_TIME_STEP  = 3'd7
    } cfg_idx_t;

    localparam logic ACT_RESTART = 1'b0;
    localparam logic ACT_NEXT    = 1'b1;

    // coefficient selector: raw coefficient or a scaled derivative term
    typedef enum logic [3:0] {
        CC_A0, CC_A1, CC_A2, CC_A2X2, CC_A3, CC_A3X3, CC_A3X6,
        CC_A4, CC_A4X4, CC_A4X12, CC_A5, CC_A5X5, CC_A5X20
    } coef_code_t;

    // controller to datapath commands
    typedef struct packed {
        logic  restart;
        logic  mul;
        logic  add;
        logic  load_out;
        step_t step;
    } qts_cmd_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    // coefficient added after the product of this step
    function automatic coef_code_t add_code(input step_t s);
        coef_code_t c;
        unique case (s)
            4'd0:    c = CC_A4;
            4'd1:    c = CC_A3;
            4'd2:    c = CC_A2;
            4'd3:    c = CC_A1;
            4'd4:    c = CC_A0;
            4'd5:    c = CC_A4X4;
            4'd6:    c = CC_A3X3;
            4'd7:    c = CC_A2X2;
            4'd8:    c = CC_A1;
            4'd9:    c = CC_A4X12;
            4'd10:   c = CC_A3X6;
            4'd11:   c = CC_A2X2;
            default: c = CC_A0;
        endcase
        return c;
    endfunction

    // leading coefficient of the polynomial that starts at this step
    function automatic coef_code_t lead_code(input step_t s);
        coef_code_t c;
        priority case (s)
            4'd5:    c = CC_A5X5;
            4'd9:    c = CC_A5X20;
            default: c = CC_A5;
        endcase
        return c;
    endfunction

    function automatic logic is_first(input step_t s);
        return (s == step_t'(0)) || (s == step_t'(5)) || (s == step_t'(9));
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qts_ctrl.sv =====
// sequencer of the sampler: input handshake, sample counter, horner step
// counter and output valid; depends on qts_pkg
`default_nettype none

module qts_ctrl
    import qts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               action,
    input  wire logic [COUNT_W-1:0] sample_count,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic                    m_tlast,
    output qts_cmd_t                cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADD, ST_OUT} state_t;

    state_t             state_reg;
    step_t              step_reg;
    logic [LEFT_W-1:0]  left_reg;
    logic               valid_reg;
    logic               last_reg;

    logic accept;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;

    always_comb
    begin
        cmd.restart  = accept && (action == ACT_RESTART);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.add      = (state_reg == ST_ADD);
        cmd.load_out = (state_reg == ST_OUT) && out_free;
        cmd.step     = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            left_reg  <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            // drained by the receiver unless a new sample lands this cycle
            if (m_tready && !cmd.load_out)
                valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (action == ACT_RESTART)
                            left_reg <= {1'b0, sample_count} + LEFT_W'(1);
                        else if (left_reg != '0)
                        begin
                            step_reg  <= '0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                    state_reg <= ST_ADD;
                ST_ADD:
                begin
                    if (step_reg == STEP_ACC_LAST)
                        state_reg <= ST_OUT;
                    else
                    begin
                        step_reg  <= step_reg + step_t'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        valid_reg <= 1'b1;
                        last_reg  <= (left_reg == LEFT_W'(1));
                        left_reg  <= left_reg - LEFT_W'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qts_dp.sv =====
// datapath of the sampler: configuration registers, scaled derivative
// coefficients, shared multiplier with round and saturate, time register
// depends on qts_pkg
`default_nettype none

module qts_dp
    import qts_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire qts_cmd_t             cmd,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    output logic signed [WORD_W-1:0]  sample_time,
    output logic signed [WORD_W-1:0]  position,
    output logic signed [WORD_W-1:0]  velocity,
    output logic signed [WORD_W-1:0]  acceleration
);

    logic signed [WORD_W-1:0]   a0_reg, a1_reg, a2_reg, a3_reg, a4_reg, a5_reg;
    logic signed [WORD_W-1:0]   a2x2_reg, a3x3_reg, a3x6_reg;
    logic signed [WORD_W-1:0]   a4x4_reg, a4x12_reg, a5x5_reg, a5x20_reg;
    logic signed [WORD_W-1:0]   start_reg;
    logic [STEP_W_T-1:0]        tstep_reg;
    logic signed [WORD_W-1:0]   time_reg;
    logic signed [WORD_W-1:0]   time_next;

    logic signed [63:0]         prod_reg;
    logic signed [WORD_W-1:0]   addc_reg;
    logic signed [WORD_W-1:0]   acc_reg;
    logic signed [WORD_W-1:0]   pos_hold_reg;
    logic signed [WORD_W-1:0]   vel_hold_reg;

    logic signed [WORD_W-1:0]   out_time_reg, out_pos_reg, out_vel_reg, out_acc_reg;

    logic signed [39:0]         wx;
    logic signed [WORD_W-1:0]   mul_a;
    logic signed [63:0]         horner_sum;
    logic signed [32:0]         time_sum;

    function automatic logic signed [WORD_W-1:0] coef_val(input coef_code_t c);
        logic signed [WORD_W-1:0] v;
        unique case (c)
            CC_A0:    v = a0_reg;
            CC_A1:    v = a1_reg;
            CC_A2:    v = a2_reg;
            CC_A2X2:  v = a2x2_reg;
            CC_A3:    v = a3_reg;
            CC_A3X3:  v = a3x3_reg;
            CC_A3X6:  v = a3x6_reg;
            CC_A4:    v = a4_reg;
            CC_A4X4:  v = a4x4_reg;
            CC_A4X12: v = a4x12_reg;
            CC_A5:    v = a5_reg;
            CC_A5X5:  v = a5x5_reg;
            CC_A5X20: v = a5x20_reg;
            default:  v = a0_reg;
        endcase
        return v;
    endfunction

    // write data sign extended for the scaled terms
    assign wx = {{8{cfg_data[WORD_W-1]}}, cfg_data};

    always_comb
    begin
        mul_a = is_first(cmd.step) ? coef_val(lead_code(cmd.step)) : acc_reg;
    end

    // round half up: floor shift plus the bit just below the point
    assign horner_sum = (prod_reg >>> FRAC_BITS)
                      + $signed({63'd0, prod_reg[FRAC_BITS-1]})
                      + $signed({{32{addc_reg[WORD_W-1]}}, addc_reg});

    // step is never negative, so only the upper bound can be hit
    assign time_sum  = $signed({time_reg[WORD_W-1], time_reg}) + $signed({2'b00, tstep_reg});
    assign time_next = (time_sum > 33'sd2147483647) ? 32'sh7fffffff : time_sum[WORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_reg    <= '0;
            a1_reg    <= '0;
            a2_reg    <= '0;
            a3_reg    <= '0;
            a4_reg    <= '0;
            a5_reg    <= '0;
            a2x2_reg  <= '0;
            a3x3_reg  <= '0;
            a3x6_reg  <= '0;
            a4x4_reg  <= '0;
            a4x12_reg <= '0;
            a5x5_reg  <= '0;
            a5x20_reg <= '0;
            start_reg <= '0;
            tstep_reg <= STEP_W_T'(65536);
            time_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_COEF_0: a0_reg <= cfg_data;
                    CFG_COEF_1: a1_reg <= cfg_data;
                    CFG_COEF_2:
                    begin
                        a2_reg   <= cfg_data;
                        a2x2_reg <= sat32(64'(wx <<< 1));
                    end
                    CFG_COEF_3:
                    begin
                        a3_reg   <= cfg_data;
                        a3x3_reg <= sat32(64'((wx <<< 1) + wx));
                        a3x6_reg <= sat32(64'((wx <<< 2) + (wx <<< 1)));
                    end
                    CFG_COEF_4:
                    begin
                        a4_reg    <= cfg_data;
                        a4x4_reg  <= sat32(64'(wx <<< 2));
                        a4x12_reg <= sat32(64'((wx <<< 3) + (wx <<< 2)));
                    end
                    CFG_COEF_5:
                    begin
                        a5_reg    <= cfg_data;
                        a5x5_reg  <= sat32(64'((wx <<< 2) + wx));
                        a5x20_reg <= sat32(64'((wx <<< 4) + (wx <<< 2)));
                    end
                    CFG_START_TIME: start_reg <= cfg_data;
                    CFG_TIME_STEP:  tstep_reg <= cfg_data[STEP_W_T-1:0];
                    default: ;
                endcase
            end
            if (cmd.restart)
                time_reg <= start_reg;
            else if (cmd.load_out)
                time_reg <= time_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= mul_a * time_reg;
            addc_reg <= coef_val(add_code(cmd.step));
        end
        if (cmd.add)
        begin
            acc_reg <= sat32(horner_sum);
            if (cmd.step == STEP_POS_LAST)
                pos_hold_reg <= sat32(horner_sum);
            if (cmd.step == STEP_VEL_LAST)
                vel_hold_reg <= sat32(horner_sum);
        end
        if (cmd.load_out)
        begin
            out_time_reg <= time_reg;
            out_pos_reg  <= pos_hold_reg;
            out_vel_reg  <= vel_hold_reg;
            out_acc_reg  <= acc_reg;
        end
    end

    assign sample_time  = out_time_reg;
    assign position     = out_pos_reg;
    assign velocity     = out_vel_reg;
    assign acceleration = out_acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/quintic_trajectory_sampler.sv =====
// top level of the quintic trajectory sampler: joins the sequencer and the
// datapath; depends on qts_pkg, qts_ctrl and qts_dp
//
// usage
//   - configuration: cfg_we/cfg_index/cfg_data write one register per cycle:
//     0..5 coefficients a0..a5, 6 start time, 7 time step (all q16.16)
//   - input stream s_*: tuser is the action (0 restart, 1 next sample),
//     tdata carries the step count n, used on restart only
//   - a restart loads n+1 samples and sets the time to the start time; it
//     produces no output
//   - each next request produces one sample on m_* (time, position, velocity,
//     acceleration); tlast marks the final one; once the run is exhausted a
//     next request is taken and dropped
//   - a next request runs twelve horner steps on one shared 32x32 multiplier,
//     each a multiply, then round/add/saturate, plus the output load; no new
//     request is taken until the sample of the current one is loaded for output
//   - stall: a finished sample sits in the output register; the next request
//     is still accepted and computed, and waits only for its own output slot
//   - reset: coefficients, start time and run counters clear, time step
//     returns to 1.0, m_tvalid drops
`default_nettype none

module quintic_trajectory_sampler
    import qts_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    // request stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [COUNT_W-1:0]   s_tdata,   // [15:0] sample_count
    input  wire logic                 s_tuser,   // [0] action
    // sample stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [4*WORD_W-1:0]       m_tdata,   // [31:0] sample_time, [63:32] position,
                                                 // [95:64] velocity, [127:96] acceleration
    output logic                      m_tlast
);

    qts_cmd_t                  cmd;
    logic signed [WORD_W-1:0]  sample_time;
    logic signed [WORD_W-1:0]  position;
    logic signed [WORD_W-1:0]  velocity;
    logic signed [WORD_W-1:0]  acceleration;

    // sequencer: handshakes, run counter, step counter
    qts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .action       (s_tuser),
        .sample_count (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tlast      (m_tlast),
        .cmd          (cmd)
    );

    // arithmetic, configuration and time keeping
    qts_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_time  (sample_time),
        .position     (position),
        .velocity     (velocity),
        .acceleration (acceleration)
    );

    assign m_tdata = {acceleration, velocity, position, sample_time};

endmodule

`default_nettype wire
